FILE: sv/pip_pkg.sv
`default_nettype none

package pip_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 24;

  // Width of the coordinate fields on the ports
  localparam int FIELD_WIDTH = 24;

  // Entries in each of the two queues
  localparam int QUEUE_DEPTH = 2;

  // Operation codes as they arrive on the input
  localparam logic [1:0] OPC_CLEAR  = 2'd0;
  localparam logic [1:0] OPC_APPEND = 2'd1;
  localparam logic [1:0] OPC_QUERY  = 2'd2;

  // Decoded command kind
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_APPEND,
    KIND_QUERY,
    KIND_NOP
  } kind_e;

  // Back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN
  } back_state_e;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [FIELD_WIDTH-1:0] x_coord;
    logic signed [FIELD_WIDTH-1:0] y_coord;
  } item_t;

  typedef struct packed {
    logic inside_res;
    logic status;
  } result_t;

  typedef struct packed {
    kind_e                         kind;
    logic signed [FIELD_WIDTH-1:0] x_coord;
    logic signed [FIELD_WIDTH-1:0] y_coord;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/point_in_polygon_test.sv
// Channel   Direction  Handshake                              Payload
// -------   ---------  -------------------------------------  ---------------------------
// item      in         push / full, transfer on push & !full  operation, x_coord, y_coord
// result    out        empty / pop, transfer on pop & !empty  inside_res, status
//
// A clear, an append or an unused code is handled in the idle state, which pushes
// its result. A query over n stored vertices takes the command, makes n + 1 reads
// on the vertex RAM read port, last vertex first, then waits in the drain state
// while the edge pipeline (read data, difference, multiply and compare, result) drains.
// Reset clears the vertex count and both queues; no clearing pass is needed.
// A full result queue holds the back end; the front queue then fills and raises full.
`default_nettype none

module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item_i,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result_o
);

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;

  // Front: decode the operation and hold items until the back end is free
  pip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  // Back: own the vertex store, walk edges for queries, queue results
  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .result_o    (result_o),
    .empty_o     (empty)
  );

endmodule

`default_nettype wire

FILE: sv/pip_ram.sv
`default_nettype none

module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pip_fifo.sv
`default_nettype none

module pip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pip_front.sv
`default_nettype none

module pip_front import pip_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  cmd_pop_i,
  output cmd_t       cmd_o,
  output logic       cmd_empty_o
);

  cmd_t cmd_in;

  // Decode the operation code into a command kind
  always_comb begin
    cmd_in.x_coord = item_i.x_coord;
    cmd_in.y_coord = item_i.y_coord;
    case (item_i.operation)
      OPC_CLEAR:  cmd_in.kind = KIND_CLEAR;
      OPC_APPEND: cmd_in.kind = KIND_APPEND;
      OPC_QUERY:  cmd_in.kind = KIND_QUERY;
      default:    cmd_in.kind = KIND_NOP;
    endcase
  end

  pip_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

`default_nettype wire

FILE: sv/pip_back.sv
`default_nettype none

module pip_back import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_empty_i,
  output logic       cmd_pop_o,
  input  wire logic  pop_i,
  output result_t    result_o,
  output logic       empty_o
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int VW    = 2 * CW;

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic [CNT_W-1:0]     cnt_m1, iss_m1;
  logic signed [CW-1:0] qx_q, qx_d, qy_q, qy_d;
  logic                 flag_q, flag_d;

  logic signed [CW-1:0] cmd_x, cmd_y;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_rdata;

  result_t res_data;
  logic    res_push, res_full;

  // Edge pipeline
  logic                 rd_v_q, rd_first_q;
  logic [VW-1:0]        prev_q;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic                 s1_v_q, s1_cross_q, s1_cross_d;
  logic signed [DW-1:0] pxa_q, pxa_d, d_q, d_d, bxa_q, bxa_d, pya_q, pya_d;
  logic                 s2_v_q, s2_cross_q, s2_dpos_q;
  logic signed [PW-1:0] lprod_q, rprod_q;
  logic                 hit;

  // Wrap the port coordinates to the internal width
  assign cmd_x = CW'($signed(cmd_i.x_coord));
  assign cmd_y = CW'($signed(cmd_i.y_coord));

  assign cnt_m1    = count_q - 1'b1;
  assign iss_m1    = iss_q - 1'b1;
  assign ram_waddr = count_q[AW-1:0];
  assign ram_raddr = (iss_q == '0) ? cnt_m1[AW-1:0] : iss_m1[AW-1:0];

  // a is the vertex just read, b the one before it
  assign ax = $signed(ram_rdata[VW-1:CW]);
  assign ay = $signed(ram_rdata[CW-1:0]);
  assign bx = $signed(prev_q[VW-1:CW]);
  assign by = $signed(prev_q[CW-1:0]);

  assign s1_cross_d = (ay > qy_q) != (by > qy_q);
  assign pxa_d      = DW'(qx_q) - DW'(ax);
  assign d_d        = DW'(by) - DW'(ay);
  assign bxa_d      = DW'(bx) - DW'(ax);
  assign pya_d      = DW'(qy_q) - DW'(ay);

  // Compare reverses when by - ay is negative, that is when a lies above b
  assign hit = s2_v_q && s2_cross_q &&
               (s2_dpos_q ? (lprod_q < rprod_q) : (rprod_q < lprod_q));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    iss_d     = iss_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    flag_d    = flag_q ^ hit;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i && !res_full) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_CLEAR: begin
              count_d  = '0;
              res_push = 1'b1;
            end
            KIND_APPEND: begin
              if (count_q == CNT_W'(MAX_VERTICES)) begin
                res_data.status = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
              res_push = 1'b1;
            end
            KIND_QUERY: begin
              qx_d   = cmd_x;
              qy_d   = cmd_y;
              flag_d = 1'b0;
              iss_d  = '0;
              if (count_q == '0) begin
                res_push = 1'b1;
              end else begin
                state_d = BK_WALK;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      BK_WALK: begin
        // Read the last vertex first, then every vertex in order
        ram_re = 1'b1;
        iss_d  = iss_q + 1'b1;
        if (iss_q == count_q) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!rd_v_q && !s1_v_q && !s2_v_q) begin
          res_push            = 1'b1;
          res_data.inside_res = flag_q;
          state_d             = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      count_q    <= '0;
      iss_q      <= '0;
      flag_q     <= 1'b0;
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      iss_q      <= iss_d;
      flag_q     <= flag_d;
      rd_v_q     <= ram_re;
      rd_first_q <= (iss_q == '0);
      s1_v_q     <= rd_v_q && !rd_first_q;
      s2_v_q     <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;
    qy_q <= qy_d;
    if (rd_v_q) begin
      prev_q <= ram_rdata;
    end
    s1_cross_q <= s1_cross_d;
    pxa_q      <= pxa_d;
    d_q        <= d_d;
    bxa_q      <= bxa_d;
    pya_q      <= pya_d;
    s2_cross_q <= s1_cross_q;
    s2_dpos_q  <= !d_q[DW-1];
    lprod_q    <= pxa_q * d_q;
    rprod_q    <= bxa_q * pya_q;
  end

  pip_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({cmd_x, cmd_y}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pip_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (result_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire
